[src/nbps_pkg.sv]
package nbps_pkg;

    // Sizes of the pattern, the window and the position counter.
    localparam int MAX_PATTERN = 64;
    localparam int IDX_BITS    = 6;
    localparam int LEN_BITS    = 7;
    localparam int POS_BITS    = 32;
    localparam int SKIP_BITS   = 6;
    localparam int BYTE_BITS   = 8;

    // Depth of the command queue between the front and back parts.
    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_BITS  = 2;

    // Widths of the stream words.
    localparam int S_DATA_BITS = 16;
    localparam int S_USER_BITS = 2;
    localparam int M_DATA_BITS = 32;
    localparam int M_USER_BITS = 1;

    // Kind of an input word.
    typedef enum logic
    {
        ACT_LOAD = 1'b0,
        ACT_DATA = 1'b1
    } action_t;

    // One decoded input word as it travels through the queue.
    typedef struct packed
    {
        action_t                 action;
        logic                    first;
        logic [IDX_BITS-1:0]     idx;
        logic [BYTE_BITS-1:0]    val;
    } cmd_t;

    // Queue fill status seen by both sides.
    typedef struct packed
    {
        logic full;
        logic empty;
    } q_stat_t;

    // Length in use: zero acts as one, values above the maximum clamp.
    function automatic logic [LEN_BITS-1:0] used_len(input logic [LEN_BITS-1:0] cfg);
        logic [LEN_BITS-1:0] res;
        begin
            res = cfg;
            if (cfg == '0)
            begin
                res = LEN_BITS'(1);
            end
            else if (cfg > LEN_BITS'(MAX_PATTERN))
            begin
                res = LEN_BITS'(MAX_PATTERN);
            end
            return res;
        end
    endfunction

endpackage

[src/nonoverlap_byte_pattern_search.sv]
// Path: a data word that completes a match passes the queue, then the issue stage,
// the window compare stage and the output register, in that order.
// Throughput: one word per cycle, set by the window shift and the pipelined 64-byte
// compare; a stalled output halts the back part and, once the queue fills, the input.
// Reset: rst_n is asynchronous, active low; it clears pattern, window, counters and
// sets the pattern length to one. No clearing pass is needed after reset.
module nonoverlap_byte_pattern_search
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [nbps_pkg::LEN_BITS-1:0]        cfg_wdata,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // tdata fields from bit 0: pattern_index[5:0], byte_value[13:6], zeros[15:14]
    input  logic [nbps_pkg::S_DATA_BITS-1:0]     s_axis_tdata,
    // tuser fields from bit 0: action[0], first_of_file[1]
    input  logic [nbps_pkg::S_USER_BITS-1:0]     s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // tdata fields from bit 0: match_position[31:0]
    output logic [nbps_pkg::M_DATA_BITS-1:0]     m_axis_tdata,
    // tuser fields from bit 0: position_saturated[0]
    output logic [nbps_pkg::M_USER_BITS-1:0]     m_axis_tuser
);
    import nbps_pkg::*;

    q_stat_t q_stat;
    cmd_t    push_cmd;
    cmd_t    pop_cmd;
    logic    q_push;
    logic    q_pop;

    // Front part: accept and classify words.
    nbps_front u_front
    (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_stat        (q_stat),
        .q_push        (q_push),
        .q_cmd         (push_cmd)
    );

    // Short queue between the two parts.
    nbps_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .cmd_in  (push_cmd),
        .pop     (q_pop),
        .cmd_out (pop_cmd),
        .q_stat  (q_stat)
    );

    // Back part: pattern store, window, compare and result.
    nbps_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .q_cmd         (pop_cmd),
        .q_stat        (q_stat),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // The back part never takes a word from an empty queue.
    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("queue popped while empty");

    // A stalled result freezes the back part.
    a_stall_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !q_pop)
        else $error("queue popped while result is stalled");

    // Match positions are 1-based.
    a_pos_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata != '0))
        else $error("match position of zero");

    // A saturated counter leaves a start position near the top of the range.
    a_sat_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (&m_axis_tdata[M_DATA_BITS-1:IDX_BITS]))
        else $error("saturated result with low position");

endmodule

[src/nbps_front.sv]
module nbps_front
(
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // tdata fields from bit 0: pattern_index[5:0], byte_value[13:6], zeros[15:14]
    input  logic [nbps_pkg::S_DATA_BITS-1:0]     s_axis_tdata,
    // tuser fields from bit 0: action[0], first_of_file[1]
    input  logic [nbps_pkg::S_USER_BITS-1:0]     s_axis_tuser,
    input  nbps_pkg::q_stat_t                    q_stat,
    output logic                                 q_push,
    output nbps_pkg::cmd_t                       q_cmd
);
    import nbps_pkg::*;

    // A word is taken whenever the queue has room.
    assign s_axis_tready = !q_stat.full;
    assign q_push        = s_axis_tvalid && !q_stat.full;

    // Classify the word; first_of_file only matters on data words.
    always_comb
    begin
        q_cmd.action = (s_axis_tuser[0] == 1'b1) ? ACT_DATA : ACT_LOAD;
        q_cmd.first  = (s_axis_tuser[0] == 1'b1) && s_axis_tuser[1];
        q_cmd.idx    = s_axis_tdata[IDX_BITS-1:0];
        q_cmd.val    = s_axis_tdata[IDX_BITS+BYTE_BITS-1:IDX_BITS];
    end

endmodule

[src/nbps_queue.sv]
module nbps_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  nbps_pkg::cmd_t    cmd_in,
    input  logic              pop,
    output nbps_pkg::cmd_t    cmd_out,
    output nbps_pkg::q_stat_t q_stat
);
    import nbps_pkg::*;

    cmd_t                  entries_reg [Q_DEPTH];
    logic [Q_PTR_BITS-1:0] wr_ptr_reg;
    logic [Q_PTR_BITS-1:0] wr_ptr_next;
    logic [Q_PTR_BITS-1:0] rd_ptr_reg;
    logic [Q_PTR_BITS-1:0] rd_ptr_next;
    logic [Q_PTR_BITS:0]   count_reg;
    logic [Q_PTR_BITS:0]   count_next;

    assign q_stat.full  = (count_reg == (Q_PTR_BITS+1)'(Q_DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign cmd_out      = entries_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

[src/nbps_back.sv]
module nbps_back
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [nbps_pkg::LEN_BITS-1:0]        cfg_wdata,
    input  nbps_pkg::cmd_t                       q_cmd,
    input  nbps_pkg::q_stat_t                    q_stat,
    output logic                                 q_pop,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // tdata fields from bit 0: match_position[31:0]
    output logic [nbps_pkg::M_DATA_BITS-1:0]     m_axis_tdata,
    // tuser fields from bit 0: position_saturated[0]
    output logic [nbps_pkg::M_USER_BITS-1:0]     m_axis_tuser
);
    import nbps_pkg::*;

    localparam logic [POS_BITS-1:0] POS_MAX = '1;

    // Configuration and stream state.
    logic [LEN_BITS-1:0]                          len_cfg_reg;
    logic [MAX_PATTERN-1:0][BYTE_BITS-1:0]        pattern_reg;
    logic [MAX_PATTERN-1:0][BYTE_BITS-1:0]        pattern_next;
    logic [MAX_PATTERN-1:0][BYTE_BITS-1:0]        window_reg;
    logic [MAX_PATTERN-1:0][BYTE_BITS-1:0]        window_next;
    logic [POS_BITS-1:0]                          bytes_seen_reg;
    logic [POS_BITS-1:0]                          bytes_seen_next;
    logic [SKIP_BITS-1:0]                         skip_reg;
    logic [SKIP_BITS-1:0]                         skip_next;

    // Pipeline registers.
    logic                                         s1_valid_reg;
    logic                                         s1_first_reg;
    logic [POS_BITS-1:0]                          s1_bs_reg;
    logic                                         s2_valid_reg;
    logic                                         s2_first_reg;
    logic                                         s2_elig_reg;
    logic [POS_BITS-1:0]                          s2_pos_reg;
    logic                                         s2_sat_reg;
    logic [MAX_PATTERN-1:0]                       s2_eq_reg;
    logic [MAX_PATTERN-1:0]                       s2_eq_next;

    // Output register.
    logic                                         out_valid_reg;
    logic                                         out_valid_next;
    logic [POS_BITS-1:0]                          out_pos_reg;
    logic                                         out_sat_reg;

    logic                                         advance;
    logic                                         issue_data;
    logic [LEN_BITS-1:0]                          len;
    logic [MAX_PATTERN-1:0][BYTE_BITS-1:0]        base_window;
    logic [POS_BITS-1:0]                          base_bs;
    logic [MAX_PATTERN-1:0][BYTE_BITS-1:0]        rev_pattern;
    logic [MAX_PATTERN-1:0][BYTE_BITS-1:0]        aligned;
    logic [IDX_BITS-1:0]                          shift_amt;
    logic [SKIP_BITS-1:0]                         skip_cur;
    logic                                         emit;

    assign len        = used_len(len_cfg_reg);
    assign advance    = !out_valid_reg || m_axis_tready;
    assign q_pop      = advance && !q_stat.empty;
    assign issue_data = q_pop && (q_cmd.action == ACT_DATA);

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_pos_reg;
    assign m_axis_tuser[0] = out_sat_reg;

    // Issue: apply a load to the pattern, or shift a byte into the window.
    always_comb
    begin
        pattern_next = pattern_reg;
        if (q_pop && (q_cmd.action == ACT_LOAD))
        begin
            pattern_next[q_cmd.idx] = q_cmd.val;
        end
        base_window = q_cmd.first ? '0 : window_reg;
        base_bs     = q_cmd.first ? '0 : bytes_seen_reg;
        window_next = window_reg;
        bytes_seen_next = bytes_seen_reg;
        if (issue_data)
        begin
            window_next     = {base_window[MAX_PATTERN-2:0], q_cmd.val};
            bytes_seen_next = (base_bs == POS_MAX) ? base_bs : base_bs + 1'b1;
        end
    end

    // Compare: line the pattern up with the newest window bytes and test each byte.
    always_comb
    begin
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            rev_pattern[i] = pattern_reg[MAX_PATTERN-1-i];
        end
        shift_amt = IDX_BITS'(LEN_BITS'(MAX_PATTERN) - len);
        aligned   = rev_pattern >> {shift_amt, 3'b000};
        for (int j = 0; j < MAX_PATTERN; j++)
        begin
            s2_eq_next[j] = (window_reg[j] == aligned[j]) || (LEN_BITS'(j) >= len);
        end
    end

    // Decide: skip count, hit detection and loading of the output register.
    always_comb
    begin
        skip_cur  = s2_first_reg ? '0 : skip_reg;
        skip_next = skip_reg;
        emit      = 1'b0;
        if (s2_valid_reg)
        begin
            skip_next = skip_cur;
            if (s2_elig_reg)
            begin
                if (skip_cur != '0)
                begin
                    skip_next = skip_cur - 1'b1;
                end
                else if (&s2_eq_reg)
                begin
                    emit      = 1'b1;
                    skip_next = SKIP_BITS'(len - 1'b1);
                end
            end
        end
        out_valid_next = out_valid_reg && !m_axis_tready;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_cfg_reg <= LEN_BITS'(1);
        end
        else if (cfg_we)
        begin
            len_cfg_reg <= cfg_wdata;
        end
    end

    // Stream state and control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg    <= '0;
            window_reg     <= '0;
            bytes_seen_reg <= '0;
            skip_reg       <= '0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                pattern_reg    <= pattern_next;
                window_reg     <= window_next;
                bytes_seen_reg <= bytes_seen_next;
                skip_reg       <= skip_next;
                s1_valid_reg   <= issue_data;
                s2_valid_reg   <= s1_valid_reg;
                out_valid_reg  <= out_valid_next;
            end
        end
    end

    // Pipeline payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_first_reg <= q_cmd.first;
            s1_bs_reg    <= bytes_seen_next;
            s2_first_reg <= s1_first_reg;
            s2_elig_reg  <= (s1_bs_reg >= POS_BITS'(len));
            s2_pos_reg   <= s1_bs_reg - POS_BITS'(len) + 1'b1;
            s2_sat_reg   <= (s1_bs_reg == POS_MAX);
            s2_eq_reg    <= s2_eq_next;
            if (emit)
            begin
                out_pos_reg <= s2_pos_reg;
                out_sat_reg <= s2_sat_reg;
            end
        end
    end

endmodule

[sim/tb_top.sv]
module tb_top;

    import nbps_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 3;
    // Margin for the pipeline latency before a length write or the end.
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_LIMIT    = 2000;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD      = 300;
    localparam int PHASE_BYTES    = 80;
    localparam int MAX_REPORTS    = 40;

    // One reported match as the block should deliver it.
    typedef struct
    {
        logic [POS_BITS-1:0] pos;
        logic                sat;
    } match_t;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_we;
    logic [LEN_BITS-1:0]     cfg_wdata;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    // tdata fields from bit 0: pattern_index[5:0], byte_value[13:6], zeros[15:14]
    logic [S_DATA_BITS-1:0]  s_axis_tdata;
    // tuser fields from bit 0: action[0], first_of_file[1]
    logic [S_USER_BITS-1:0]  s_axis_tuser;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    // tdata fields from bit 0: match_position[31:0]
    logic [M_DATA_BITS-1:0]  m_axis_tdata;
    // tuser fields from bit 0: position_saturated[0]
    logic [M_USER_BITS-1:0]  m_axis_tuser;

    // Mirror of the search state.
    logic [BYTE_BITS-1:0]    pattern_copy [MAX_PATTERN];
    logic [BYTE_BITS-1:0]    recent [MAX_PATTERN];
    logic [POS_BITS-1:0]     byte_count;
    int                      skip_left;
    logic [LEN_BITS-1:0]     length_reg;
    match_t                  expected_hits [$];

    int                      err_count   = 0;
    int                      idle_cycles = 0;

    // Sender pacing.
    int                      burst_left  = 0;
    bit                      steady_send = 1'b0;

    // Receiver pacing; hold_left forces a long stall when set.
    int                      hold_left   = 0;
    int                      rx_mode     = 0;
    int                      rx_mode_left = 0;
    int                      rx_tick     = 0;

    // Byte alphabet of the current search phase.
    logic [BYTE_BITS-1:0]    sym_lo;
    logic [BYTE_BITS-1:0]    sym_hi;
    bit                      wide_bytes;

    nonoverlap_byte_pattern_search dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #CLK_HALF clk = ~clk;

    // Length in use for matching: zero acts as one, large values clamp.
    function automatic int effective_length(input logic [LEN_BITS-1:0] raw);
        if (raw == '0)
        begin
            return 1;
        end
        if (raw > MAX_PATTERN)
        begin
            return MAX_PATTERN;
        end
        return int'(raw);
    endfunction

    function automatic void clear_search_state();
        foreach (pattern_copy[k])
        begin
            pattern_copy[k] = '0;
            recent[k]       = '0;
        end
        byte_count = '0;
        skip_left  = 0;
        length_reg = LEN_BITS'(1);
    endfunction

    // Update the mirror with one accepted word and queue the match it causes.
    function automatic void predict_word(input action_t act,
                                         input logic [IDX_BITS-1:0] idx,
                                         input logic [BYTE_BITS-1:0] val,
                                         input logic first);
        int     len;
        logic   same;
        match_t m;

        if (act == ACT_LOAD)
        begin
            pattern_copy[idx] = val;
            return;
        end

        // A new file restarts the counter, the window and the skip count.
        if (first)
        begin
            foreach (recent[k])
            begin
                recent[k] = '0;
            end
            byte_count = '0;
            skip_left  = 0;
        end

        for (int k = MAX_PATTERN - 1; k > 0; k--)
        begin
            recent[k] = recent[k-1];
        end
        recent[0] = val;
        if (byte_count != '1)
        begin
            byte_count = byte_count + 1'b1;
        end

        len = effective_length(length_reg);
        if (byte_count < len)
        begin
            return;
        end
        if (skip_left > 0)
        begin
            skip_left--;
            return;
        end

        // The oldest byte of the window lines up with pattern byte 0.
        same = 1'b1;
        for (int k = 0; k < len; k++)
        begin
            if (pattern_copy[k] != recent[len-1-k])
            begin
                same = 1'b0;
            end
        end
        if (!same)
        begin
            return;
        end

        skip_left = len - 1;
        // The counter is as wide as the output field, so no clamp is needed.
        m.pos = byte_count - POS_BITS'(len) + 1'b1;
        m.sat = (byte_count == '1);
        expected_hits.push_back(m);
    endfunction

    // Print one line per mismatch, but keep the log short when many go wrong.
    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        if (err_count < MAX_REPORTS)
        begin
            $display("MISMATCH at %0t: %s: got %0d, expected %0d", $realtime, what,
                     got, want);
        end
        err_count++;
    endtask

    // Offer one word in bursts with random gaps, then predict on acceptance.
    task automatic send_word(input action_t act, input logic [IDX_BITS-1:0] idx,
                             input logic [BYTE_BITS-1:0] val, input logic first);
        int gap;

        if (!steady_send && burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        if (burst_left > 0)
        begin
            burst_left--;
        end

        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, val, idx};
        s_axis_tuser  <= {first, act};
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        predict_word(act, idx, val, first);
    endtask

    task automatic send_data(input logic [BYTE_BITS-1:0] val, input logic first);
        send_word(ACT_DATA, IDX_BITS'($urandom_range(0, MAX_PATTERN - 1)), val, first);
    endtask

    task automatic load_byte(input logic [IDX_BITS-1:0] idx,
                             input logic [BYTE_BITS-1:0] val);
        send_word(ACT_LOAD, idx, val, 1'($urandom_range(0, 1)));
    endtask

    // Stop sending and wait until every expected match has come out.
    task automatic settle_idle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        for (int w = 0; w < DRAIN_LIMIT && expected_hits.size() != 0; w++)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_length(input logic [LEN_BITS-1:0] raw);
        settle_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= raw;
        @(posedge clk);
        cfg_we    <= 1'b0;
        length_reg = raw;
    endtask

    function automatic logic [BYTE_BITS-1:0] pick_byte();
        if (wide_bytes)
        begin
            return BYTE_BITS'($urandom_range(0, 255));
        end
        return ($urandom_range(0, 1) == 1) ? sym_hi : sym_lo;
    endfunction

    // Length one from reset with an all-zero pattern; loads ignore first_of_file.
    task automatic test_reset_state();
        send_data(8'h00, 1'b1);
        send_data(8'h00, 1'b0);
        send_data(8'h80, 1'b0);
        send_word(ACT_LOAD, 6'd0, 8'hFF, 1'b1);
        send_data(8'hFF, 1'b0);
        send_word(ACT_LOAD, 6'd63, 8'h00, 1'b0);
        send_data(8'h00, 1'b0);
        send_data(8'hFF, 1'b0);
    endtask

    // A zero length behaves as a length of one.
    task automatic test_length_zero();
        write_length(LEN_BITS'(0));
        load_byte(6'd0, 8'h5A);
        send_data(8'h5A, 1'b1);
        send_data(8'h00, 1'b0);
        send_data(8'h5A, 1'b0);
    endtask

    // Repeated bytes: hits must not overlap, and a short window never compares.
    task automatic test_overlap_skip();
        write_length(LEN_BITS'(2));
        load_byte(6'd0, 8'h61);
        load_byte(6'd1, 8'h61);
        send_data(8'h61, 1'b1);
        repeat (4) send_data(8'h61, 1'b0);
    endtask

    // A new file mid-match drops the partial window.
    task automatic test_file_restart();
        load_byte(6'd1, 8'h62);
        send_data(8'h61, 1'b1);
        send_data(8'h62, 1'b0);
        send_data(8'h61, 1'b0);
        send_data(8'h62, 1'b1);
        send_data(8'h62, 1'b0);
    endtask

    // One length setting: load a pattern, then stream copies of it among noise.
    task automatic run_search_phase(input logic [LEN_BITS-1:0] raw, input int data_items);
        int                   len;
        int                   sent;
        int                   roll;
        logic [IDX_BITS-1:0]  idx;
        logic [BYTE_BITS-1:0] val;
        logic [BYTE_BITS-1:0] want [MAX_PATTERN];
        logic                 pending_first;

        write_length(raw);
        len        = effective_length(raw);
        wide_bytes = ($urandom_range(0, 3) == 0);
        sym_lo     = BYTE_BITS'($urandom_range(0, 255));
        sym_hi     = BYTE_BITS'($urandom_range(0, 255));

        for (int k = 0; k < len; k++)
        begin
            want[k] = pick_byte();
            load_byte(IDX_BITS'(k), want[k]);
        end

        // Without a new file the window carries over from the previous length.
        pending_first = 1'($urandom_range(0, 1));
        sent = 0;
        while (sent < data_items)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 5)
            begin
                idx = IDX_BITS'($urandom_range(0, MAX_PATTERN - 1));
                val = BYTE_BITS'($urandom_range(0, 255));
                load_byte(idx, val);
                want[idx] = val;
            end
            else if (roll < 55)
            begin
                for (int k = 0; k < len; k++)
                begin
                    send_data(want[k], pending_first ||
                              (k == 0 && $urandom_range(0, 9) == 0));
                    pending_first = 1'b0;
                end
                sent += len;
            end
            else
            begin
                send_data(pick_byte(), pending_first || ($urandom_range(0, 49) == 0));
                pending_first = 1'b0;
                sent++;
            end
        end
    endtask

    task automatic test_random_search();
        int lengths [] = '{3, 1, 0, 2, 64, 5, 127, 7, 65, 4, 12, 2, 31, 6};

        foreach (lengths[i])
        begin
            run_search_phase(LEN_BITS'(lengths[i]), PHASE_BYTES);
        end
    endtask

    // Every byte matches while the receiver holds off, so the block backs up.
    task automatic test_output_backpressure();
        write_length(LEN_BITS'(1));
        load_byte(6'd0, 8'h3C);
        steady_send = 1'b1;
        hold_left   = LONG_HOLD;
        send_data(8'h3C, 1'b1);
        repeat (79) send_data(8'h3C, 1'b0);
        steady_send = 1'b0;
    endtask

    // Receiver stall patterns, switched at random, plus the forced long hold.
    always @(posedge clk)
    begin
        if (rx_mode_left == 0)
        begin
            rx_mode      = $urandom_range(0, 2);
            rx_mode_left = $urandom_range(30, 300);
        end
        else
        begin
            rx_mode_left--;
        end
        rx_tick++;

        if (hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left--;
        end
        else
        begin
            case (rx_mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= ($urandom_range(0, 2) != 0);
                default: m_axis_tready <= ((rx_tick % 5) < 3);
            endcase
        end
    end

    // Compare each delivered match with the oldest expectation.
    always @(posedge clk)
    begin
        match_t want;

        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_hits.size() == 0)
            begin
                report_mismatch("match with nothing pending", m_axis_tdata, 0);
            end
            else
            begin
                want = expected_hits.pop_front();
                if (m_axis_tdata != want.pos)
                begin
                    report_mismatch("match_position", m_axis_tdata, want.pos);
                end
                if (m_axis_tuser[0] != want.sat)
                begin
                    report_mismatch("position_saturated", m_axis_tuser[0], want.sat);
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("Timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_wdata     <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        m_axis_tready <= 1'b0;
        clear_search_state();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_length_zero();
        test_overlap_skip();
        test_file_restart();
        test_random_search();
        test_output_backpressure();

        settle_idle();
        if (expected_hits.size() != 0)
        begin
            report_mismatch("matches never delivered", 0, expected_hits.size());
        end
        if (err_count == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[filelist.f]
src/nbps_pkg.sv
src/nbps_front.sv
src/nbps_queue.sv
src/nbps_back.sv
src/nonoverlap_byte_pattern_search.sv
sim/tb_top.sv
